[src/mexp_pkg.sv]
// Shared types, constants and the microcode program of the modular exponentiation block.
// No dependencies; mexp_mulmod, mexp_seq and the top level refer to this package by scoped names.

package mexp_pkg;

  localparam int DATA_W    = 32;
  localparam int MOD_BITS  = 32;
  localparam int EXP_BITS  = 32;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int IDX_W     = $clog2(EXP_BITS);
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPONENT = 2'd0,
    REG_MODULUS  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_MUL,
    OP_TEST,
    OP_NEXT,
    OP_DONE,
    OP_ERR
  } op_t;

  typedef enum logic [1:0] {
    X_BASE,
    X_RES,
    X_SQR
  } xsel_t;

  typedef enum logic {
    A_ONE,
    A_SQR
  } asel_t;

  typedef enum logic {
    DST_RES,
    DST_SQR
  } dst_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_INIT   = 3'd0;
  localparam step_t STEP_REDUCE = 3'd1;
  localparam step_t STEP_TEST   = 3'd2;
  localparam step_t STEP_MULT   = 3'd3;
  localparam step_t STEP_SQUARE = 3'd4;
  localparam step_t STEP_NEXT   = 3'd5;
  localparam step_t STEP_DONE   = 3'd6;
  localparam step_t STEP_ERR    = 3'd7;

  // One control word of the program.
  typedef struct packed {
    op_t   op;
    xsel_t xsel;
    asel_t asel;
    dst_t  dst;
    step_t target;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic  load_init;
    logic  mul_start;
    logic  mul_wr;
    xsel_t xsel;
    asel_t asel;
    dst_t  dst;
    logic  out_fire;
    logic  out_err;
  } ctl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic mod_zero;
    logic mul_done;
  } sts_t;

  function automatic uword_t rom_word(step_t s);
    uword_t w;
    w = '{op: OP_DONE, xsel: X_BASE, asel: A_ONE, dst: DST_RES, target: STEP_INIT};
    unique case (s)
      STEP_INIT:   w = '{op: OP_INIT, xsel: X_BASE, asel: A_ONE, dst: DST_RES,
                         target: STEP_ERR};
      STEP_REDUCE: w = '{op: OP_MUL,  xsel: X_BASE, asel: A_ONE, dst: DST_SQR,
                         target: STEP_INIT};
      STEP_TEST:   w = '{op: OP_TEST, xsel: X_BASE, asel: A_ONE, dst: DST_RES,
                         target: STEP_SQUARE};
      STEP_MULT:   w = '{op: OP_MUL,  xsel: X_RES,  asel: A_SQR, dst: DST_RES,
                         target: STEP_INIT};
      STEP_SQUARE: w = '{op: OP_MUL,  xsel: X_SQR,  asel: A_SQR, dst: DST_SQR,
                         target: STEP_INIT};
      STEP_NEXT:   w = '{op: OP_NEXT, xsel: X_BASE, asel: A_ONE, dst: DST_RES,
                         target: STEP_TEST};
      STEP_DONE:   w = '{op: OP_DONE, xsel: X_BASE, asel: A_ONE, dst: DST_RES,
                         target: STEP_INIT};
      STEP_ERR:    w = '{op: OP_ERR,  xsel: X_BASE, asel: A_ONE, dst: DST_RES,
                         target: STEP_INIT};
      default:     w = '{op: OP_DONE, xsel: X_BASE, asel: A_ONE, dst: DST_RES,
                         target: STEP_INIT};
    endcase
    return w;
  endfunction

endpackage

[src/mexp_mulmod.sv]
// Bit-serial modular multiplier: prod = x * a mod m, one multiplier bit per cycle, MSB first.
// Depends on mexp_pkg. Requires a < m and m nonzero.

module mexp_mulmod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mexp_pkg::DATA_W-1:0]   x,
  input  logic [mexp_pkg::MOD_BITS-1:0] a,
  input  logic [mexp_pkg::MOD_BITS-1:0] m,
  output logic                          done,
  output logic [mexp_pkg::MOD_BITS-1:0] prod
);

  localparam int W2 = mexp_pkg::MOD_BITS + 2;

  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [mexp_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [mexp_pkg::DATA_W-1:0]   x_r, x_nxt;
  logic [mexp_pkg::MOD_BITS-1:0] acc_r, acc_nxt;
  logic [W2-1:0]                 t, m1, m2, red;

  // Doubling plus an optional addend stays below 3m, so one of three candidates is right.
  always_comb begin
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    t   = {1'b0, acc_r, 1'b0} + (x_r[mexp_pkg::DATA_W-1] ? {2'b00, a} : '0);
    if (t >= m2) begin
      red = t - m2;
    end else if (t >= m1) begin
      red = t - m1;
    end else begin
      red = t;
    end
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      x_nxt   = x;
      acc_nxt = '0;
    end else if (run_r) begin
      acc_nxt = red[mexp_pkg::MOD_BITS-1:0];
      x_nxt   = {x_r[mexp_pkg::DATA_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mexp_pkg::CNT_W'(mexp_pkg::DATA_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[src/mexp_seq.sv]
// Microcode sequencer: step counter, program table lookup, exponent bit counter and jumps.
// Depends on mexp_pkg for the control word layout and the program itself.

module mexp_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mexp_pkg::EXP_BITS-1:0] exponent,
  input  mexp_pkg::sts_t                sts,
  output logic                          busy,
  output mexp_pkg::ctl_t                ctl
);

  logic                       busy_r, busy_nxt;
  logic                       wait_r, wait_nxt;
  mexp_pkg::step_t            pc_r, pc_nxt;
  logic [mexp_pkg::IDX_W-1:0] idx_r, idx_nxt;
  mexp_pkg::uword_t           uw;
  mexp_pkg::step_t            pc_inc;

  always_comb begin
    uw        = mexp_pkg::rom_word(pc_r);
    pc_inc    = mexp_pkg::step_t'(pc_r + 3'd1);
    busy_nxt  = busy_r;
    wait_nxt  = wait_r;
    pc_nxt    = pc_r;
    idx_nxt   = idx_r;
    ctl           = '0;
    ctl.xsel      = uw.xsel;
    ctl.asel      = uw.asel;
    ctl.dst       = uw.dst;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        wait_nxt = 1'b0;
        pc_nxt   = mexp_pkg::STEP_INIT;
      end
    end else begin
      unique case (uw.op)
        mexp_pkg::OP_INIT: begin
          ctl.load_init = 1'b1;
          idx_nxt       = '0;
          pc_nxt        = sts.mod_zero ? uw.target : pc_inc;
        end
        mexp_pkg::OP_MUL: begin
          if (!wait_r) begin
            ctl.mul_start = 1'b1;
            wait_nxt      = 1'b1;
          end else if (sts.mul_done) begin
            ctl.mul_wr = 1'b1;
            wait_nxt   = 1'b0;
            pc_nxt     = pc_inc;
          end
        end
        mexp_pkg::OP_TEST: begin
          pc_nxt = exponent[idx_r] ? pc_inc : uw.target;
        end
        mexp_pkg::OP_NEXT: begin
          if (idx_r == mexp_pkg::IDX_W'(mexp_pkg::EXP_BITS - 1)) begin
            pc_nxt = pc_inc;
          end else begin
            idx_nxt = idx_r + 1'b1;
            pc_nxt  = uw.target;
          end
        end
        mexp_pkg::OP_DONE: begin
          ctl.out_fire = 1'b1;
          busy_nxt     = 1'b0;
        end
        mexp_pkg::OP_ERR: begin
          ctl.out_fire = 1'b1;
          ctl.out_err  = 1'b1;
          busy_nxt     = 1'b0;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      wait_r <= 1'b0;
      pc_r   <= mexp_pkg::STEP_INIT;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      wait_r <= wait_nxt;
      pc_r   <= pc_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign busy = busy_r;

endmodule

[src/modular_exponentiation_top.sv]
// Top level of the modular exponentiation block: configuration registers, operand registers,
// result register. Depends on mexp_pkg, mexp_mulmod and mexp_seq.
//
//   Channel   Handshake                  Payload                       Direction
//   input     start / busy               in_base[31:0]                 in
//   result    out_valid (one-cycle)      out_result, out_modulus_error out
//   config    cfg_valid / cfg_ready      cfg_index[1:0], cfg_data      in
//
// A base word is taken when start is high and busy is low; one result word follows.
// Each exponent bit costs one squaring and each set bit one extra multiplication, all done by
// the bit-serial multiplier after one reduction of the base. A zero modulus returns the error
// word without running the multiplier.
// rst_n is synchronous and active low; it restores exponent and modulus to 1.
// Results cannot be stalled; out_valid is a strobe of exactly one cycle per word.

module modular_exponentiation_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    in_base,
  output logic                           out_valid,
  output logic [31:0]                    out_result,
  output logic                           out_modulus_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  // Configuration registers hold only the bits that the datapath uses.
  logic [mexp_pkg::EXP_BITS-1:0] exp_r;
  logic [mexp_pkg::MOD_BITS-1:0] mod_r;

  // Operand registers: the latched base, the running result and the running square.
  logic [mexp_pkg::DATA_W-1:0]   base_r;
  logic [mexp_pkg::MOD_BITS-1:0] res_r;
  logic [mexp_pkg::MOD_BITS-1:0] sqr_r;

  logic                          out_valid_r;
  logic [31:0]                   out_result_r;
  logic                          out_err_r;

  mexp_pkg::ctl_t                ctl;
  mexp_pkg::sts_t                sts;

  logic [mexp_pkg::MOD_BITS-1:0] one_mod;
  logic [mexp_pkg::DATA_W-1:0]   mul_x;
  logic [mexp_pkg::MOD_BITS-1:0] mul_a;
  logic [mexp_pkg::MOD_BITS-1:0] mul_prod;
  logic                          mul_done;
  logic                          accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // 1 mod m is 0 only when the modulus is one. The initial reduction of the base is then
  // simply base * (1 mod m) through the same multiplier.
  assign one_mod = (mod_r == mexp_pkg::MOD_BITS'(1)) ? '0 : mexp_pkg::MOD_BITS'(1);

  assign sts.mod_zero = (mod_r == '0);
  assign sts.mul_done = mul_done;

  always_comb begin
    case (ctl.xsel)
      mexp_pkg::X_BASE: mul_x = base_r;
      mexp_pkg::X_RES:  mul_x = mexp_pkg::DATA_W'(res_r);
      mexp_pkg::X_SQR:  mul_x = mexp_pkg::DATA_W'(sqr_r);
      default:          mul_x = '0;
    endcase
    case (ctl.asel)
      mexp_pkg::A_ONE: mul_a = one_mod;
      mexp_pkg::A_SQR: mul_a = sqr_r;
      default:         mul_a = '0;
    endcase
  end

  mexp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .exponent (exp_r),
    .sts      (sts),
    .busy     (busy),
    .ctl      (ctl)
  );

  mexp_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.mul_start),
    .x     (mul_x),
    .a     (mul_a),
    .m     (mod_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Register writes must come only while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= mexp_pkg::EXP_BITS'(1);
      mod_r <= mexp_pkg::MOD_BITS'(1);
    end else if (cfg_valid) begin
      if (cfg_index == mexp_pkg::REG_EXPONENT) begin
        exp_r <= cfg_data[mexp_pkg::EXP_BITS-1:0];
      end else if (cfg_index == mexp_pkg::REG_MODULUS) begin
        mod_r <= cfg_data[mexp_pkg::MOD_BITS-1:0];
      end
    end
  end

  // Operand registers carry payload only and need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      base_r <= in_base;
    end
    if (ctl.load_init) begin
      res_r <= one_mod;
    end else if (ctl.mul_wr && ctl.dst == mexp_pkg::DST_RES) begin
      res_r <= mul_prod;
    end
    if (ctl.mul_wr && ctl.dst == mexp_pkg::DST_SQR) begin
      sqr_r <= mul_prod;
    end
    if (ctl.out_fire) begin
      out_result_r <= ctl.out_err ? '0 : 32'(res_r);
      out_err_r    <= ctl.out_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.out_fire;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result        = out_result_r;
  assign out_modulus_error = out_err_r;

endmodule

[src/mexp_checker.sv]
// Port-level checker for the modular exponentiation block and the bind that attaches it.
// Depends on modular_exponentiation_top.

module mexp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_result,
  input logic        out_modulus_error
);

  // An accepted word makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // A result appears only once the block has gone idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // Each word gives a single one-cycle strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The error word always carries a zero result.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_modulus_error |-> out_result == 32'd0)
    else $error("modulus error with nonzero result");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);
